>>> sv/mep_pkg.sv
// shared types, constants and palette for the mandelbrot escape pixel block
// no dependencies; used by every module under sv/
package mep_pkg;

  localparam int FracBits     = 28;
  localparam int MaxImageSide = 4096;
  localparam int QueueDepth   = 2;

  localparam int ColW   = 12;
  localparam int OrigW  = 32;
  localparam int StepW  = 31;
  localparam int CntW   = 16;
  localparam int ColorW = 8;
  localparam int IdxW   = 3;
  localparam int DataW  = 32;

  // product of index and step, then c with origin added
  localparam int PW = ColW + StepW;
  localparam int CW = PW + 2;
  // z is clamped to +-4.0, squares stay at or below 16.0
  localparam int ZW = FracBits + 4;
  localparam int SW = FracBits + 6;
  // next z before clamping
  localparam int NW = CW + 2;

  localparam logic signed [NW-1:0] FourN =
    {{(NW - FracBits - 3){1'b0}}, 1'b1, {(FracBits + 2){1'b0}}};
  localparam logic signed [SW:0] FourS =
    {{(SW - FracBits - 2){1'b0}}, 1'b1, {(FracBits + 2){1'b0}}};

  typedef enum logic [IdxW-1:0] {
    CfgOriginX = 3'd0,
    CfgOriginY = 3'd1,
    CfgStepX   = 3'd2,
    CfgStepY   = 3'd3,
    CfgIterLim = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [OrigW-1:0] origin_x;
    logic signed [OrigW-1:0] origin_y;
    logic [StepW-1:0]        step_x;
    logic [StepW-1:0]        step_y;
    logic [CntW-1:0]         iteration_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    origin_x:        32'shD800_0000,
    origin_y:        32'shE000_0000,
    step_x:          31'd1048576,
    step_y:          31'd1048576,
    iteration_limit: 16'd200
  };

  typedef struct packed {
    logic [ColW-1:0] pixel_col;
    logic [ColW-1:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [ColW-1:0]   out_col;
    logic [ColW-1:0]   out_row;
    logic [CntW-1:0]   escape_count;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pix_out_t;

  typedef struct packed {
    logic [ColW-1:0]      col;
    logic [ColW-1:0]      row;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } job_t;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic prod_busy;
    logic sum_busy;
  } front_stat_t;

  localparam rgb_t InsideRgb = '{red: 8'd16, green: 8'd16, blue: 8'd16};

  function automatic rgb_t palette(input logic [3:0] idx);
    rgb_t c;
    unique case (idx)
      4'd0:    c = '{8'd66,  8'd30,  8'd15};
      4'd1:    c = '{8'd25,  8'd7,   8'd26};
      4'd2:    c = '{8'd9,   8'd1,   8'd47};
      4'd3:    c = '{8'd4,   8'd4,   8'd73};
      4'd4:    c = '{8'd0,   8'd7,   8'd100};
      4'd5:    c = '{8'd12,  8'd44,  8'd138};
      4'd6:    c = '{8'd24,  8'd82,  8'd177};
      4'd7:    c = '{8'd57,  8'd125, 8'd209};
      4'd8:    c = '{8'd134, 8'd181, 8'd229};
      4'd9:    c = '{8'd211, 8'd236, 8'd248};
      4'd10:   c = '{8'd241, 8'd233, 8'd191};
      4'd11:   c = '{8'd248, 8'd201, 8'd95};
      4'd12:   c = '{8'd255, 8'd170, 8'd0};
      4'd13:   c = '{8'd204, 8'd128, 8'd0};
      4'd14:   c = '{8'd153, 8'd87,  8'd0};
      default: c = '{8'd106, 8'd52,  8'd3};
    endcase
    return c;
  endfunction

endpackage

>>> sv/mep_front.sv
// front end: takes pixel transactions, forms the complex point c and snaps c_y
// depends on mep_pkg
module mep_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mep_pkg::pix_in_t     in_data_i,
  input  mep_pkg::cfg_t        cfg_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output mep_pkg::job_t        job_o,
  output mep_pkg::front_stat_t stat_o
);

  logic                          a_v_q, a_v_d;
  logic [mep_pkg::ColW-1:0]      a_col_q, a_row_q;
  logic [mep_pkg::PW-1:0]        a_px_q, a_py_q;
  logic                          b_v_q, b_v_d;
  logic [mep_pkg::ColW-1:0]      b_col_q, b_row_q;
  logic signed [mep_pkg::CW-1:0] b_cx_q, b_cy_q;
  logic signed [mep_pkg::CW-1:0] cx_d, cy_d;
  logic [mep_pkg::ColW-1:0]      ecol, erow;
  logic                          a_en, b_en;
  logic signed [mep_pkg::CW:0]   cy2, sy;
  logic                          snap;

  assign b_en       = !b_v_q || job_ready_i;
  assign a_en       = !a_v_q || b_en;
  assign in_ready_o = a_en;

  // index saturation to the image side
  always_comb begin
    ecol = in_data_i.pixel_col;
    erow = in_data_i.pixel_row;
    if (32'(in_data_i.pixel_col) >= mep_pkg::MaxImageSide) begin
      ecol = mep_pkg::ColW'(mep_pkg::MaxImageSide - 1);
    end
    if (32'(in_data_i.pixel_row) >= mep_pkg::MaxImageSide) begin
      erow = mep_pkg::ColW'(mep_pkg::MaxImageSide - 1);
    end
  end

  always_comb begin
    cx_d = $signed({{(mep_pkg::CW - mep_pkg::OrigW){cfg_i.origin_x[mep_pkg::OrigW-1]}},
                    cfg_i.origin_x})
         + $signed({{(mep_pkg::CW - mep_pkg::PW){1'b0}}, a_px_q});
    cy_d = $signed({{(mep_pkg::CW - mep_pkg::OrigW){cfg_i.origin_y[mep_pkg::OrigW-1]}},
                    cfg_i.origin_y})
         + $signed({{(mep_pkg::CW - mep_pkg::PW){1'b0}}, a_py_q});
  end

  assign a_v_d = a_en ? in_valid_i : a_v_q;
  assign b_v_d = b_en ? a_v_q : b_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= a_v_d;
      b_v_q <= b_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && in_valid_i) begin
      a_col_q <= in_data_i.pixel_col;
      a_row_q <= in_data_i.pixel_row;
      a_px_q  <= mep_pkg::PW'(ecol) * mep_pkg::PW'(cfg_i.step_x);
      a_py_q  <= mep_pkg::PW'(erow) * mep_pkg::PW'(cfg_i.step_y);
    end
    if (b_en && a_v_q) begin
      b_col_q <= a_col_q;
      b_row_q <= a_row_q;
      b_cx_q  <= cx_d;
      b_cy_q  <= cy_d;
    end
  end

  // exact test 2*|c_y| < step_y
  assign cy2  = {b_cy_q, 1'b0};
  assign sy   = $signed({{(mep_pkg::CW + 1 - mep_pkg::StepW){1'b0}}, cfg_i.step_y});
  assign snap = (cy2 < sy) && (cy2 > -sy);

  assign job_valid_o = b_v_q;
  always_comb begin
    job_o.col = b_col_q;
    job_o.row = b_row_q;
    job_o.cx  = b_cx_q;
    job_o.cy  = snap ? '0 : b_cy_q;
  end

  assign stat_o.prod_busy = a_v_q;
  assign stat_o.sum_busy  = b_v_q;

endmodule

>>> sv/mep_fifo.sv
// short queue of prepared points between front end and iteration engine
// depends on mep_pkg
module mep_fifo #(
  parameter int Depth = mep_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mep_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mep_pkg::job_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mep_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/mep_engine.sv
// iteration engine: runs z = z^2 + c, counts iterations, colors the result
// depends on mep_pkg
module mep_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  input  mep_pkg::job_t       job_i,
  input  mep_pkg::cfg_t       cfg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mep_pkg::pix_out_t   out_data_o
);

  localparam int ZW = mep_pkg::ZW;
  localparam int SW = mep_pkg::SW;
  localparam int NW = mep_pkg::NW;
  localparam int CW = mep_pkg::CW;
  localparam int F  = mep_pkg::FracBits;
  localparam logic signed [NW-1:0] FourN    = mep_pkg::FourN;
  localparam logic signed [NW-1:0] NegFourN = -mep_pkg::FourN;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StCheck = 3'b010,
    StMul   = 3'b100
  } eng_state_e;

  eng_state_e                   state_q, state_d;
  logic [mep_pkg::ColW-1:0]     col_q, row_q;
  logic signed [CW-1:0]         cx_q, cy_q;
  logic signed [ZW-1:0]         zx_q, zy_q, zx_d, zy_d;
  logic signed [SW-1:0]         sx_q, sy_q, pxy_q;
  logic [mep_pkg::CntW-1:0]     cnt_q;
  logic signed [2*ZW-1:0]       mxx, myy, mxy;
  logic signed [NW-1:0]         nx, ny;
  logic signed [SW:0]           mag;
  logic                         go_on, out_free, finish;
  logic                         out_valid_q;
  mep_pkg::pix_out_t            out_q;
  mep_pkg::rgb_t                rgb;

  function automatic logic signed [ZW-1:0] clamp_z(input logic signed [NW-1:0] v);
    logic signed [ZW-1:0] r;
    if (v > FourN) begin
      r = FourN[ZW-1:0];
    end else if (v < NegFourN) begin
      r = NegFourN[ZW-1:0];
    end else begin
      r = v[ZW-1:0];
    end
    return r;
  endfunction

  // floor of product >> F is the arithmetic shift of the exact product
  assign mxx = (2*ZW)'(zx_q) * (2*ZW)'(zx_q);
  assign myy = (2*ZW)'(zy_q) * (2*ZW)'(zy_q);
  assign mxy = (2*ZW)'(zx_q) * (2*ZW)'(zy_q);

  assign nx = $signed({{(NW - SW){sx_q[SW-1]}}, sx_q})
            - $signed({{(NW - SW){sy_q[SW-1]}}, sy_q})
            + $signed({{(NW - CW){cx_q[CW-1]}}, cx_q});
  assign ny = $signed({{(NW - SW - 1){pxy_q[SW-1]}}, pxy_q, 1'b0})
            + $signed({{(NW - CW){cy_q[CW-1]}}, cy_q});
  assign zx_d = clamp_z(nx);
  assign zy_d = clamp_z(ny);

  assign mag   = $signed({sx_q[SW-1], sx_q}) + $signed({sy_q[SW-1], sy_q});
  assign go_on = (cnt_q < cfg_i.iteration_limit) && (mag < mep_pkg::FourS);

  assign out_free  = !out_valid_q || out_ready_i;
  assign finish    = (state_q == StCheck) && !go_on && out_free;
  assign job_pop_o = (state_q == StIdle) && job_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (go_on) begin
          state_d = StMul;
        end else if (out_free) begin
          state_d = StIdle;
        end
      end
      StMul: begin
        state_d = StCheck;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign rgb = (cnt_q == cfg_i.iteration_limit) ? mep_pkg::InsideRgb
                                                : mep_pkg::palette(cnt_q[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      col_q <= job_i.col;
      row_q <= job_i.row;
      cx_q  <= job_i.cx;
      cy_q  <= job_i.cy;
      sx_q  <= '0;
      sy_q  <= '0;
      pxy_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == StCheck && go_on) begin
      zx_q  <= zx_d;
      zy_q  <= zy_d;
      cnt_q <= cnt_q + 1'b1;
    end
    if (state_q == StMul) begin
      sx_q  <= mxx[F +: SW];
      sy_q  <= myy[F +: SW];
      pxy_q <= mxy[F +: SW];
    end
    if (finish) begin
      out_q.out_col      <= col_q;
      out_q.out_row      <= row_q;
      out_q.escape_count <= cnt_q;
      out_q.red          <= rgb.red;
      out_q.green        <= rgb.green;
      out_q.blue         <= rgb.blue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/mandelbrot_escape_pixel.sv
// top level of the mandelbrot escape pixel block: config registers, front end,
// queue and iteration engine; depends on mep_pkg, mep_front, mep_fifo, mep_engine
//
//   port group  direction  handshake              payload
//   in          input      in_valid_i/in_ready_o    mep_pkg::pix_in_t
//   out         output     out_valid_o/out_ready_i  mep_pkg::pix_out_t
//   cfg         input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// an item passes the front-end product and sum registers, then the engine, which runs
// its loop once per counted iteration (at most iteration_limit); the engine's loop
// (add and clamp, then multiply) sets the rate
// reset is asynchronous: config back to defaults, queue and result empty
// a stalled result waits in the output register; the queue lets the front end
// keep taking transactions meanwhile, until the queue and front end fill
module mandelbrot_escape_pixel #(
  parameter int QUEUE_DEPTH = mep_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mep_pkg::pix_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mep_pkg::pix_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mep_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [mep_pkg::DataW-1:0]   cfg_data_i
);

  mep_pkg::cfg_t        cfg_q, cfg_d;
  mep_pkg::job_t        job_push, job_pop;
  mep_pkg::front_stat_t front_stat;
  logic                 push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mep_pkg::cfg_idx_e'(cfg_index_i))
        mep_pkg::CfgOriginX: cfg_d.origin_x = $signed(cfg_data_i);
        mep_pkg::CfgOriginY: cfg_d.origin_y = $signed(cfg_data_i);
        mep_pkg::CfgStepX:   cfg_d.step_x   = cfg_data_i[mep_pkg::StepW-1:0];
        mep_pkg::CfgStepY:   cfg_d.step_y   = cfg_data_i[mep_pkg::StepW-1:0];
        mep_pkg::CfgIterLim: cfg_d.iteration_limit = cfg_data_i[mep_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mep_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .job_valid_o (push),
    .job_ready_i (!q_full),
    .job_o       (job_push),
    .stat_o      (front_stat)
  );

  mep_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !q_full),
    .data_i  (job_push),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (job_pop)
  );

  mep_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_pop_o   (pop),
    .job_i       (job_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("engine popped an empty queue");

  a_full_holds_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.sum_busy && q_full |=> front_stat.sum_busy)
    else $error("front end dropped a point while the queue was full");

  a_accept_fills_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> front_stat.prod_busy)
    else $error("accepted transaction not held in the front end");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// testbench for mandelbrot_escape_pixel: directed and random pixels under changing view
// settings, each result checked against an escape-time predictor; needs mep_pkg and sv/
module tb;
  import mep_pkg::*;

  localparam int SettleCycles = 8;
  localparam logic [IdxW-1:0] FirstSpareIdx = IdxW'(CfgIterLim + 1);
  localparam logic [IdxW-1:0] LastSpareIdx  = '1;

  typedef enum int {NoIdle, SenderIdle, ReceiverStall, BothIdle} idle_mode_e;

  class escape_board;
    cfg_t         regs;
    pix_out_t     awaited[$];
    int unsigned  mismatch_count;
    rgb_t         gradient [16];

    function new();
      regs.origin_x        = -671088640;
      regs.origin_y        = -536870912;
      regs.step_x          = StepW'(1048576);
      regs.step_y          = StepW'(1048576);
      regs.iteration_limit = CntW'(200);
      mismatch_count       = 0;
      gradient = '{'{8'd66, 8'd30, 8'd15}, '{8'd25, 8'd7, 8'd26}, '{8'd9, 8'd1, 8'd47},
                   '{8'd4, 8'd4, 8'd73}, '{8'd0, 8'd7, 8'd100}, '{8'd12, 8'd44, 8'd138},
                   '{8'd24, 8'd82, 8'd177}, '{8'd57, 8'd125, 8'd209},
                   '{8'd134, 8'd181, 8'd229}, '{8'd211, 8'd236, 8'd248},
                   '{8'd241, 8'd233, 8'd191}, '{8'd248, 8'd201, 8'd95},
                   '{8'd255, 8'd170, 8'd0}, '{8'd204, 8'd128, 8'd0},
                   '{8'd153, 8'd87, 8'd0}, '{8'd106, 8'd52, 8'd3}};
    endfunction

    function void note_write(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
      case (idx)
        CfgOriginX: regs.origin_x = data;
        CfgOriginY: regs.origin_y = data;
        CfgStepX:   regs.step_x = data[StepW-1:0];
        CfgStepY:   regs.step_y = data[StepW-1:0];
        CfgIterLim: regs.iteration_limit = data[CntW-1:0];
        default: ;
      endcase
    endfunction

    function pix_out_t predict_pixel(pix_in_t px);
      longint      four, ecol, erow, cx, cy, zx, zy, sx, sy, nx, ny;
      int unsigned n;
      rgb_t        tint;
      pix_out_t    r;
      four = longint'(4) <<< FracBits;
      ecol = (px.pixel_col >= MaxImageSide) ? MaxImageSide - 1 : px.pixel_col;
      erow = (px.pixel_row >= MaxImageSide) ? MaxImageSide - 1 : px.pixel_row;
      cx = longint'(regs.origin_x) + ecol * longint'(regs.step_x);
      cy = longint'(regs.origin_y) + erow * longint'(regs.step_y);
      // c_y within half a step of zero snaps to the real axis
      if (2 * (cy < 0 ? -cy : cy) < longint'(regs.step_y)) cy = 0;
      zx = 0;
      zy = 0;
      sx = 0;
      sy = 0;
      n  = 0;
      while (n < regs.iteration_limit && sx + sy < four) begin
        nx = sx - sy + cx;
        ny = 2 * ((zx * zy) >>> FracBits) + cy;
        zx = (nx > four) ? four : (nx < -four) ? -four : nx;
        zy = (ny > four) ? four : (ny < -four) ? -four : ny;
        sx = (zx * zx) >>> FracBits;
        sy = (zy * zy) >>> FracBits;
        n++;
      end
      if (n == regs.iteration_limit) begin
        tint = '{8'd16, 8'd16, 8'd16};
      end else begin
        tint = gradient[n[3:0]];
      end
      r.out_col      = px.pixel_col;
      r.out_row      = px.pixel_row;
      r.escape_count = n[CntW-1:0];
      r.red          = tint.red;
      r.green        = tint.green;
      r.blue         = tint.blue;
      return r;
    endfunction

    function void note_pixel(pix_in_t px);
      awaited.push_back(predict_pixel(px));
    endfunction

    task report_mismatch(string field, logic [ColW-1:0] col, logic [ColW-1:0] row,
                         logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s at pixel (%0d,%0d): got %0d, expected %0d",
               field, col, row, got, want);
      mismatch_count++;
    endtask

    task check_pixel(pix_out_t got);
      pix_out_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing pending", got.out_col, got.out_row, 0, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.out_col !== want.out_col)
        report_mismatch("out_col", want.out_col, want.out_row, got.out_col, want.out_col);
      if (got.out_row !== want.out_row)
        report_mismatch("out_row", want.out_col, want.out_row, got.out_row, want.out_row);
      if (got.escape_count !== want.escape_count)
        report_mismatch("escape_count", want.out_col, want.out_row, got.escape_count,
                        want.escape_count);
      if (got.red !== want.red)
        report_mismatch("red", want.out_col, want.out_row, got.red, want.red);
      if (got.green !== want.green)
        report_mismatch("green", want.out_col, want.out_row, got.green, want.green);
      if (got.blue !== want.blue)
        report_mismatch("blue", want.out_col, want.out_row, got.blue, want.blue);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pix_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pix_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index = '0;
  logic [DataW-1:0]  cfg_data = '0;

  escape_board board = new();
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  mandelbrot_escape_pixel DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("mandelbrot_escape_pixel verification failed");
    $finish;
  end

  // receiver: long hold-off when asked, random stalls otherwise
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_pixel(out_data);
  end

  task automatic cfg_write(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.note_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(pix_in_t px);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(px);
  endtask

  // drop valid and wait until every pending pixel has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    px.pixel_col = ColW'($urandom);
    px.pixel_row = ColW'($urandom);
    if ($urandom_range(7) == 0) px.pixel_col = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(7) == 0) px.pixel_row = $urandom_range(1) ? '1 : '0;
    return px;
  endfunction

  task automatic pick_settings();
    int unsigned      kind;
    logic [DataW-1:0] ox, oy, sx, sy, lim;
    kind = $urandom_range(9);
    if (kind <= 5) begin
      // window over the set, so counts spread out
      ox  = -671088640 + int'($urandom_range(1 << 28)) - (1 << 27);
      oy  = -536870912 + int'($urandom_range(1 << 28)) - (1 << 27);
      sx  = $urandom_range(1 << 18, 1 << 16);
      sy  = $urandom_range(1 << 18, 1 << 16);
      lim = ($urandom_range(7) == 0) ? 200 : $urandom_range(40, 1);
    end else if (kind <= 7) begin
      ox  = $urandom;
      oy  = $urandom;
      sx  = $urandom;
      sy  = $urandom;
      lim = $urandom_range(40, 1);
    end else begin
      ox  = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      oy  = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sx  = $urandom_range(1) ? '0 : '1;
      sy  = $urandom_range(1) ? '0 : '1;
      lim = $urandom_range(2);
    end
    cfg_write(CfgOriginX, ox);
    cfg_write(CfgOriginY, oy);
    cfg_write(CfgStepX, sx);
    cfg_write(CfgStepY, sy);
    cfg_write(CfgIterLim, lim);
    if ($urandom_range(2) == 0)
      cfg_write(IdxW'($urandom_range(LastSpareIdx, FirstSpareIdx)), $urandom);
  endtask

  task automatic random_phase(int unsigned count, idle_mode_e mode);
    idle_pct  = (mode == SenderIdle) ? 62 : (mode == BothIdle) ? 31 : 0;
    stall_pct = (mode == ReceiverStall) ? 62 : (mode == BothIdle) ? 31 : 0;
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset view: corners, origin, real axis, near the cusp
    send_pixel('{12'd0, 12'd0});
    send_pixel('{12'd4095, 12'd4095});
    send_pixel('{12'd0, 12'd4095});
    send_pixel('{12'd4095, 12'd0});
    send_pixel('{12'd640, 12'd512});
    send_pixel('{12'd384, 12'd512});
    send_pixel('{12'd448, 12'd576});
    send_pixel('{12'd707, 12'd512});
    settle();

    // c_y of exactly half a step is kept, just under it snaps to zero
    cfg_write(CfgOriginY, -524288);
    send_pixel('{12'd707, 12'd0});
    send_pixel('{12'd707, 12'd1});
    settle();
    cfg_write(CfgOriginY, -524287);
    send_pixel('{12'd707, 12'd0});
    settle();

    // zero limit, then a limit of one
    cfg_write(CfgIterLim, 0);
    send_pixel('{12'd0, 12'd0});
    send_pixel('{12'd640, 12'd512});
    settle();
    cfg_write(CfgIterLim, 1);
    send_pixel('{12'd0, 12'd0});
    send_pixel('{12'd640, 12'd512});
    settle();

    // spare indexes must leave the registers alone
    cfg_write(FirstSpareIdx, '0);
    cfg_write(LastSpareIdx, '1);
    send_pixel('{12'd640, 12'd512});
    settle();

    cfg_write(CfgOriginX, 32'h8000_0000);
    cfg_write(CfgOriginY, 32'h7FFF_FFFF);
    cfg_write(CfgStepX, '1);
    cfg_write(CfgStepY, '0);
    cfg_write(CfgIterLim, 32'h0000_FFFF);
    send_pixel('{12'd0, 12'd0});
    send_pixel('{12'd1, 12'd4095});
    send_pixel('{12'd4095, 12'd4095});
    settle();

    // c = 0 runs to the full limit
    cfg_write(CfgOriginX, 0);
    cfg_write(CfgOriginY, 0);
    cfg_write(CfgStepX, 0);
    send_pixel('{12'd4095, 12'd4095});

    for (int ph = 0; ph < 14; ph++) begin
      settle();
      pick_settings();
      random_phase(100, idle_mode_e'(ph % 4));
      if (ph == 6) begin
        // back pressure: receiver holds off while the sender keeps offering
        settle();
        hold_cycles = 400;
        random_phase(16, NoIdle);
        settle();
        random_phase(16, NoIdle);
      end
    end

    settle();
    if (board.mismatch_count == 0) begin
      $display("mandelbrot_escape_pixel verification clean");
    end else begin
      $display("mandelbrot_escape_pixel verification failed");
    end
    $finish;
  end

endmodule
